FILE: sv/wpf_pkg.sv
`default_nettype none
package wpf_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [23:0] delta_time;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic        moving;
    logic        stopped;
    logic [1:0]  stop_reason;
    logic        queue_full;
  } out_word_t;

  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_APP  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] RSN_NONE = 2'd0;
  localparam logic [1:0] RSN_DONE = 2'd1;
  localparam logic [1:0] RSN_ZERO = 2'd2;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_ROOT = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  localparam logic [2:0] K_SQ = 3'd0;
  localparam logic [2:0] K_RT = 3'd1;
  localparam logic [2:0] K_FC = 3'd2;
  localparam logic [2:0] K_PF = 3'd3;
  localparam logic [2:0] K_MV = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       set_pos;
    logic       append;
    logic       stop_zero;
    logic       load_wp;
    logic       eng_start;
    logic       eng_take;
    logic [2:0] eng_kind;
    logic [1:0] ax;
    logic       snap;
    logic       pass;
    logic       end_tick;
    logic       vel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       active;
    logic       speed_zero;
    logic       loop_ok;
    logic       dist_zero;
    logic       can_pass;
    logic       eng_done;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/waypoint_path_follower.sv
// A word is taken when start is high while busy is low, and its result word is shown on
// out_data for exactly one cycle with out_valid high; the receiver cannot stall, so it
// must capture the word in that cycle. Setting the position, appending a waypoint or an
// idle tick steps through S_EXEC, S_VEL once for each axis and S_OUT. A tick passes
// each waypoint with three squarings, a square root and three direction divisions,
// handles a waypoint it already sits on with the squarings and the root alone, and for
// the waypoint it only steps part of the way toward adds a fraction division and three
// multiplies, up to MAX_PASSES_PER_TICK waypoints; all of this runs one bit per cycle
// through a single shared multiply, root and divide unit.
`default_nettype none
module waypoint_path_follower #(
  parameter int QUEUE_DEPTH         = 16,
  parameter int MAX_PASSES_PER_TICK = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire wpf_pkg::in_word_t  in_data,
  output logic                    out_valid,
  output wpf_pkg::out_word_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);

  wpf_pkg::dp_cmd_t    cmd;
  wpf_pkg::dp_status_t status;

  wpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  wpf_dp #(
    .QUEUE_DEPTH         (QUEUE_DEPTH),
    .MAX_PASSES_PER_TICK (MAX_PASSES_PER_TICK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: sv/wpf_arith.sv
`default_nettype none
module wpf_arith (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  op,
  input  wire logic [65:0] opa,
  input  wire logic [33:0] opb,
  input  wire logic [65:0] init,
  output logic             done,
  output logic [65:0]      acc,
  output logic [33:0]      quo
);

  localparam logic [5:0] MUL_STEPS  = 6'd33;
  localparam logic [5:0] ROOT_STEPS = 6'd33;
  localparam logic [5:0] DIV_STEPS  = 6'd32;

  logic [1:0]  op_r;
  logic [65:0] acc_r;
  logic [65:0] mc_r;
  logic [35:0] rem_r;
  logic [33:0] q_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [35:0] rem_sq;
  logic [35:0] trial;
  logic [35:0] rem_dv;
  logic [35:0] den36;
  logic [65:0] acc_add;

  always_comb begin
    rem_sq  = {rem_r[33:0], acc_r[65:64]};
    trial   = {q_r, 2'b01};
    rem_dv  = {rem_r[34:0], 1'b0};
    den36   = {2'b00, mc_r[33:0]};
    acc_add = acc_r + (q_r[0] ? mc_r : 66'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        op_r <= op;
        case (op)
          wpf_pkg::OP_MUL: begin
            acc_r  <= init;
            mc_r   <= opa;
            q_r    <= opb;
            cnt_r  <= MUL_STEPS;
            busy_r <= 1'b1;
          end
          wpf_pkg::OP_ROOT: begin
            acc_r  <= opa;
            rem_r  <= '0;
            q_r    <= '0;
            cnt_r  <= ROOT_STEPS;
            busy_r <= 1'b1;
          end
          wpf_pkg::OP_DIV: begin
            mc_r  <= {32'd0, opb};
            rem_r <= {2'b00, opa[33:0]};
            if (opa[33:0] >= opb) begin
              q_r    <= 34'h1_0000_0000;
              done_r <= 1'b1;
            end else begin
              q_r    <= '0;
              cnt_r  <= DIV_STEPS;
              busy_r <= 1'b1;
            end
          end
          default: begin
            done_r <= 1'b1;
          end
        endcase
      end else if (busy_r) begin
        case (op_r)
          wpf_pkg::OP_MUL: begin
            acc_r <= acc_add;
            mc_r  <= {mc_r[64:0], 1'b0};
            q_r   <= {1'b0, q_r[33:1]};
          end
          wpf_pkg::OP_ROOT: begin
            acc_r <= {acc_r[63:0], 2'b00};
            if (rem_sq >= trial) begin
              rem_r <= rem_sq - trial;
              q_r   <= {q_r[32:0], 1'b1};
            end else begin
              rem_r <= rem_sq;
              q_r   <= {q_r[32:0], 1'b0};
            end
          end
          wpf_pkg::OP_DIV: begin
            if (rem_dv >= den36) begin
              rem_r <= rem_dv - den36;
              q_r   <= {q_r[32:0], 1'b1};
            end else begin
              rem_r <= rem_dv;
              q_r   <= {q_r[32:0], 1'b0};
            end
          end
          default: begin
            q_r <= q_r;
          end
        endcase
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

FILE: sv/wpf_dp.sv
`default_nettype none
module wpf_dp #(
  parameter int QUEUE_DEPTH         = 16,
  parameter int MAX_PASSES_PER_TICK = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wpf_pkg::in_word_t   in_data,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  input  wire wpf_pkg::dp_cmd_t    cmd,
  output wpf_pkg::dp_status_t      status,
  output wpf_pkg::out_word_t       out_data
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(MAX_PASSES_PER_TICK + 1);

  logic [95:0]   mem [QUEUE_DEPTH];
  logic [95:0]   rd_r;

  wpf_pkg::in_word_t in_r;
  logic [31:0]   speed_r;
  logic [31:0]   pos_r [3];
  logic [31:0]   fac_r [3];
  logic [31:0]   vel_r [3];
  logic [31:0]   tgt_r [3];
  logic [32:0]   m_r [3];
  logic          neg_r [3];
  logic [QW-1:0] head_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] passes_r;
  logic          active_r;
  logic          stopped_r;
  logic [1:0]    reason_r;
  logic          qfull_r;
  logic [55:0]   budget_r;
  logic [65:0]   sum_r;
  logic [32:0]   dist_r;
  logic [31:0]   f_r;

  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [QW-1:0] tail;
  logic [QW-1:0] head_next;
  logic          full;
  logic [55:0]   bud_prod;
  logic [55:0]   dist_sh;
  logic [32:0]   d_w [3];
  logic [31:0]   rd_c [3];

  logic          eng_done;
  logic [65:0]   eng_acc;
  logic [33:0]   eng_quo;
  logic [1:0]    eng_op;
  logic [65:0]   eng_a;
  logic [33:0]   eng_b;
  logic [65:0]   eng_init;

  logic [31:0]   fac_u;
  logic [32:0]   mv;
  logic [32:0]   pos_new;
  logic [31:0]   vmag;
  logic [62:0]   vprod;
  logic [63:0]   vrnd;
  logic [33:0]   vr;
  logic [33:0]   vrs;
  logic [31:0]   vel_w;

  always_comb begin
    tail_sum  = (CW+1)'(head_r) + (CW+1)'(cnt_r);
    tail_wrap = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ? tail_sum - (CW+1)'(QUEUE_DEPTH)
                                                   : tail_sum;
    tail      = tail_wrap[QW-1:0];
    head_next = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    full      = (cnt_r >= CW'(QUEUE_DEPTH));
    bud_prod  = speed_r * in_data.delta_time;
    dist_sh   = {7'd0, dist_r, 16'd0};
    rd_c[0]   = rd_r[31:0];
    rd_c[1]   = rd_r[63:32];
    rd_c[2]   = rd_r[95:64];
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {rd_c[i][31], rd_c[i]} - {pos_r[i][31], pos_r[i]};
    end
  end

  always_comb begin
    eng_op   = wpf_pkg::OP_MUL;
    eng_a    = 66'(m_r[cmd.ax]);
    eng_b    = 34'(m_r[cmd.ax]);
    eng_init = (cmd.ax == 2'd0) ? 66'd0 : sum_r;
    case (cmd.eng_kind)
      wpf_pkg::K_SQ: begin
        eng_op = wpf_pkg::OP_MUL;
      end
      wpf_pkg::K_RT: begin
        eng_op = wpf_pkg::OP_ROOT;
        eng_a  = sum_r;
      end
      wpf_pkg::K_FC: begin
        eng_op = wpf_pkg::OP_DIV;
        eng_b  = 34'(dist_r);
      end
      wpf_pkg::K_PF: begin
        eng_op = wpf_pkg::OP_DIV;
        eng_a  = 66'(budget_r[49:16]);
        eng_b  = 34'(dist_r);
      end
      wpf_pkg::K_MV: begin
        eng_op   = wpf_pkg::OP_MUL;
        eng_b    = 34'(f_r);
        eng_init = 66'h8000_0000;
      end
      default: begin
        eng_op = wpf_pkg::OP_MUL;
      end
    endcase
  end

  wpf_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.eng_start),
    .op    (eng_op),
    .opa   (eng_a),
    .opb   (eng_b),
    .init  (eng_init),
    .done  (eng_done),
    .acc   (eng_acc),
    .quo   (eng_quo)
  );

  always_comb begin
    fac_u   = eng_quo[33:2];
    mv      = eng_acc[64:32];
    pos_new = neg_r[cmd.ax] ? {pos_r[cmd.ax][31], pos_r[cmd.ax]} - mv
                            : {pos_r[cmd.ax][31], pos_r[cmd.ax]} + mv;
    vmag    = fac_r[cmd.ax][31] ? 32'd0 - fac_r[cmd.ax] : fac_r[cmd.ax];
    vprod   = vmag[30:0] * speed_r;
    vrnd    = {1'b0, vprod} + 64'h2000_0000;
    vr      = vrnd[63:30];
    vrs     = (vr > 34'h0_8000_0000) ? 34'h0_8000_0000 : vr;
    if (!active_r) begin
      vel_w = 32'd0;
    end else if (fac_r[cmd.ax][31]) begin
      vel_w = 32'd0 - vrs[31:0];
    end else if (vr > 34'h0_7FFF_FFFF) begin
      vel_w = 32'h7FFF_FFFF;
    end else begin
      vel_w = vr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[tail] <= {in_r.coord_z, in_r.coord_y, in_r.coord_x};
    end
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= '0;
      head_r   <= '0;
      cnt_r    <= '0;
      active_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        fac_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        speed_r <= cfg_wdata;
      end
      if (cmd.latch) begin
        in_r      <= in_data;
        budget_r  <= bud_prod;
        passes_r  <= '0;
        stopped_r <= 1'b0;
        reason_r  <= wpf_pkg::RSN_NONE;
        qfull_r   <= 1'b0;
      end
      if (cmd.set_pos) begin
        pos_r[0] <= in_r.coord_x;
        pos_r[1] <= in_r.coord_y;
        pos_r[2] <= in_r.coord_z;
        head_r   <= '0;
        cnt_r    <= '0;
        active_r <= 1'b0;
      end
      if (cmd.append) begin
        if (full) begin
          qfull_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
        active_r <= 1'b1;
      end
      if (cmd.stop_zero) begin
        cnt_r     <= '0;
        active_r  <= 1'b0;
        stopped_r <= 1'b1;
        reason_r  <= wpf_pkg::RSN_ZERO;
      end
      if (cmd.load_wp) begin
        for (int i = 0; i < 3; i++) begin
          tgt_r[i] <= rd_c[i];
          neg_r[i] <= d_w[i][32];
          m_r[i]   <= d_w[i][32] ? 33'd0 - d_w[i] : d_w[i];
        end
      end
      if (cmd.eng_take) begin
        case (cmd.eng_kind)
          wpf_pkg::K_SQ: sum_r <= eng_acc;
          wpf_pkg::K_RT: dist_r <= eng_quo[32:0];
          wpf_pkg::K_FC: fac_r[cmd.ax] <= neg_r[cmd.ax] ? 32'd0 - fac_u : fac_u;
          wpf_pkg::K_PF: f_r <= eng_quo[31:0];
          wpf_pkg::K_MV: pos_r[cmd.ax] <= pos_new[31:0];
          default: f_r <= f_r;
        endcase
      end
      if (cmd.snap || cmd.pass) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= tgt_r[i];
        end
        head_r   <= head_next;
        cnt_r    <= cnt_r - 1'b1;
        passes_r <= passes_r + 1'b1;
      end
      if (cmd.pass) begin
        budget_r <= budget_r - dist_sh;
      end
      if (cmd.end_tick && cnt_r == '0) begin
        active_r  <= 1'b0;
        stopped_r <= 1'b1;
        reason_r  <= wpf_pkg::RSN_DONE;
      end
      if (cmd.vel) begin
        vel_r[cmd.ax] <= vel_w;
      end
    end
  end

  always_comb begin
    status.action     = in_r.action;
    status.active     = active_r;
    status.speed_zero = (speed_r == 32'd0);
    status.loop_ok    = (budget_r != 56'd0) && (cnt_r != '0) &&
                        (passes_r < PW'(MAX_PASSES_PER_TICK));
    status.dist_zero  = (dist_r == 33'd0);
    status.can_pass   = (dist_sh <= budget_r);
    status.eng_done   = eng_done;

    out_data.pos_x       = pos_r[0];
    out_data.pos_y       = pos_r[1];
    out_data.pos_z       = pos_r[2];
    out_data.vel_x       = vel_r[0];
    out_data.vel_y       = vel_r[1];
    out_data.vel_z       = vel_r[2];
    out_data.moving      = active_r;
    out_data.stopped     = stopped_r;
    out_data.stop_reason = reason_r;
    out_data.queue_full  = qfull_r;
  end

endmodule
`default_nettype wire

FILE: sv/wpf_ctrl.sv
`default_nettype none
module wpf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire wpf_pkg::dp_status_t status,
  output logic                     busy,
  output logic                     out_valid,
  output wpf_pkg::dp_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_ENG   = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_DZ    = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_ENDT  = 4'd9;
  localparam logic [3:0] S_VEL   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [1:0] ax_r, ax_nxt;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    ax_nxt       = ax_r;
    cmd          = '0;
    cmd.eng_kind = kind_r;
    cmd.ax       = ax_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ax_nxt    = 2'd0;
        state_nxt = S_VEL;
        case (status.action)
          wpf_pkg::ACT_SET: cmd.set_pos = 1'b1;
          wpf_pkg::ACT_APP: cmd.append = 1'b1;
          wpf_pkg::ACT_TICK: begin
            if (status.active && status.speed_zero) begin
              cmd.stop_zero = 1'b1;
            end else if (status.active) begin
              state_nxt = S_CHECK;
            end
          end
          default: state_nxt = S_VEL;
        endcase
      end
      S_CHECK: begin
        state_nxt = status.loop_ok ? S_FETCH : S_ENDT;
      end
      S_FETCH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_wp = 1'b1;
        kind_nxt    = wpf_pkg::K_SQ;
        ax_nxt      = 2'd0;
        state_nxt   = S_ENG;
      end
      S_ENG: begin
        cmd.eng_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (status.eng_done) begin
          cmd.eng_take = 1'b1;
          case (kind_r)
            wpf_pkg::K_SQ: begin
              if (ax_r != 2'd2) begin
                ax_nxt = ax_r + 2'd1;
              end else begin
                kind_nxt = wpf_pkg::K_RT;
              end
              state_nxt = S_ENG;
            end
            wpf_pkg::K_RT: state_nxt = S_DZ;
            wpf_pkg::K_FC: begin
              if (ax_r != 2'd2) begin
                ax_nxt    = ax_r + 2'd1;
                state_nxt = S_ENG;
              end else begin
                state_nxt = S_CMP;
              end
            end
            wpf_pkg::K_PF: begin
              kind_nxt  = wpf_pkg::K_MV;
              ax_nxt    = 2'd0;
              state_nxt = S_ENG;
            end
            wpf_pkg::K_MV: begin
              if (ax_r != 2'd2) begin
                ax_nxt    = ax_r + 2'd1;
                state_nxt = S_ENG;
              end else begin
                state_nxt = S_ENDT;
              end
            end
            default: state_nxt = S_ENDT;
          endcase
        end
      end
      S_DZ: begin
        if (status.dist_zero) begin
          cmd.snap  = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          kind_nxt  = wpf_pkg::K_FC;
          ax_nxt    = 2'd0;
          state_nxt = S_ENG;
        end
      end
      S_CMP: begin
        if (status.can_pass) begin
          cmd.pass  = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          kind_nxt  = wpf_pkg::K_PF;
          state_nxt = S_ENG;
        end
      end
      S_ENDT: begin
        cmd.end_tick = 1'b1;
        ax_nxt       = 2'd0;
        state_nxt    = S_VEL;
      end
      S_VEL: begin
        cmd.vel = 1'b1;
        if (ax_r != 2'd2) begin
          ax_nxt = ax_r + 2'd1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= wpf_pkg::K_SQ;
      ax_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      ax_r    <= ax_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule
`default_nettype wire

FILE: sim/waypoint_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module waypoint_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire wpf_pkg::in_word_t  in_data,
  input  wire logic               out_valid,
  input  wire wpf_pkg::out_word_t out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  output int                      errors,
  output int                      pending
);

  localparam int DEPTH     = 16;
  localparam int MAX_HOPS  = 16;

  logic [31:0]        speed_q;
  longint             pos [3];
  longint             face [3];
  longint             wp_store [DEPTH][3];
  int                 head;
  int                 count;
  bit                 active;
  wpf_pkg::out_word_t expected_words [8];
  int                 wr_ptr;
  int                 rd_ptr;

  function automatic longint unsigned distance_of(longint unsigned m0, longint unsigned m1,
                                                  longint unsigned m2);
    logic [69:0] sum;
    logic [69:0] cand;
    logic [33:0] root;
    sum = 70'(m0) * 70'(m0) + 70'(m1) * 70'(m1) + 70'(m2) * 70'(m2);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = 70'(root | (34'd1 << b));
      if (cand * cand <= sum) root = cand[33:0];
    end
    return 64'(root);
  endfunction

  function automatic longint unsigned ratio32(longint unsigned num, longint unsigned den);
    logic [127:0] t;
    if (den == 0) return 0;
    if (num >= den) return 64'd1 << 32;
    t = 128'(num) << 32;
    return 64'(t / 128'(den));
  endfunction

  function automatic logic [31:0] velocity_of(longint f);
    logic [127:0] r;
    longint unsigned mag;
    mag = (f < 0) ? longint'(-f) : f;
    r = (128'(mag) * 128'(speed_q) + (128'd1 << 29)) >> 30;
    if (f < 0) begin
      if (r > 128'h8000_0000) r = 128'h8000_0000;
      return 32'(-r);
    end
    if (r > 128'h7FFF_FFFF) r = 128'h7FFF_FFFF;
    return r[31:0];
  endfunction

  function automatic void drop_head();
    head = (head + 1) % DEPTH;
    count--;
  endfunction

  function automatic wpf_pkg::out_word_t follow(wpf_pkg::in_word_t w);
    wpf_pkg::out_word_t r;
    longint          c [3];
    longint          d [3];
    longint unsigned m [3];
    longint unsigned budget;
    longint unsigned span;
    longint unsigned f;
    longint          mv;
    int              hops;
    int              slot;
    r = '0;
    c[0] = longint'($signed(w.coord_x));
    c[1] = longint'($signed(w.coord_y));
    c[2] = longint'($signed(w.coord_z));
    if (w.action == wpf_pkg::ACT_SET) begin
      for (int i = 0; i < 3; i++) pos[i] = c[i];
      head = 0;
      count = 0;
      active = 0;
    end else if (w.action == wpf_pkg::ACT_APP) begin
      if (count < DEPTH) begin
        slot = (head + count) % DEPTH;
        for (int i = 0; i < 3; i++) wp_store[slot][i] = c[i];
        count++;
      end else begin
        r.queue_full = 1'b1;
      end
      active = 1;
    end else if (w.action == wpf_pkg::ACT_TICK && active) begin
      if (speed_q == 0) begin
        count = 0;
        active = 0;
        r.stopped = 1'b1;
        r.stop_reason = wpf_pkg::RSN_ZERO;
      end else begin
        budget = 64'(speed_q) * 64'(w.delta_time);
        hops = 0;
        while (budget > 0 && count > 0 && hops < MAX_HOPS) begin
          for (int i = 0; i < 3; i++) begin
            d[i] = wp_store[head][i] - pos[i];
            m[i] = (d[i] < 0) ? -d[i] : d[i];
          end
          span = distance_of(m[0], m[1], m[2]);
          if (span == 0) begin
            for (int i = 0; i < 3; i++) pos[i] = wp_store[head][i];
            drop_head();
            hops++;
            continue;
          end
          for (int i = 0; i < 3; i++) begin
            mv = longint'(ratio32(m[i], span) >> 2);
            face[i] = (d[i] < 0) ? -mv : mv;
          end
          if ((span << 16) <= budget) begin
            budget -= span << 16;
            for (int i = 0; i < 3; i++) pos[i] = wp_store[head][i];
            drop_head();
            hops++;
            continue;
          end
          f = ratio32(budget >> 16, span);
          for (int i = 0; i < 3; i++) begin
            mv = longint'((128'(m[i]) * 128'(f) + 128'h8000_0000) >> 32);
            pos[i] += (d[i] < 0) ? -mv : mv;
          end
          break;
        end
        if (count == 0) begin
          active = 0;
          r.stopped = 1'b1;
          r.stop_reason = wpf_pkg::RSN_DONE;
        end
      end
    end
    r.pos_x = pos[0][31:0];
    r.pos_y = pos[1][31:0];
    r.pos_z = pos[2][31:0];
    if (active) begin
      r.vel_x = velocity_of(face[0]);
      r.vel_y = velocity_of(face[1]);
      r.vel_z = velocity_of(face[2]);
    end
    r.moving = active;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    wpf_pkg::out_word_t e;
    if (!rst_n) begin
      speed_q = '0;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0;
        face[i] = 0;
      end
      head = 0;
      count = 0;
      active = 0;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (cfg_we) speed_q = cfg_wdata;
      if (start && !busy) begin
        expected_words[wr_ptr[2:0]] = follow(in_data);
        wr_ptr++;
      end
      if (out_valid) begin
        if (wr_ptr == rd_ptr) begin
          errors++;
          $display("%0t: result word with none expected, got %h", $time, out_data);
        end else begin
          e = expected_words[rd_ptr[2:0]];
          rd_ptr++;
          compare_field("pos_x", e.pos_x, out_data.pos_x);
          compare_field("pos_y", e.pos_y, out_data.pos_y);
          compare_field("pos_z", e.pos_z, out_data.pos_z);
          compare_field("vel_x", e.vel_x, out_data.vel_x);
          compare_field("vel_y", e.vel_y, out_data.vel_y);
          compare_field("vel_z", e.vel_z, out_data.vel_z);
          compare_field("moving", 32'(e.moving), 32'(out_data.moving));
          compare_field("stopped", 32'(e.stopped), 32'(out_data.stopped));
          compare_field("stop_reason", 32'(e.stop_reason), 32'(out_data.stop_reason));
          compare_field("queue_full", 32'(e.queue_full), 32'(out_data.queue_full));
        end
      end
    end
    pending = wr_ptr - rd_ptr;
  end
endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam logic [1:0] ACT_PEEK   = 2'd3;
  localparam int         IDLE_LIMIT = 60000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  wpf_pkg::in_word_t  in_data;
  logic      out_valid;
  wpf_pkg::out_word_t out_data;
  logic      cfg_we;
  logic [31:0] cfg_wdata;
  int        errors;
  int        pending;
  int        idle_pct;
  int        quiet_cycles;

  waypoint_path_follower i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  waypoint_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_word(logic [1:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [23:0] dt);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{action: act, coord_x: x, coord_y: y, coord_z: z, delta_time: dt};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic write_speed(logic [31:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] near(logic [31:0] c, int spread_log);
    return c + 32'($signed($urandom_range(0, (1 << spread_log) - 1)) - (1 << (spread_log - 1)));
  endfunction

  function automatic logic [23:0] tick_len();
    if ($urandom_range(7) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 1 << 18));
  endfunction

  initial begin
    logic [31:0] cx, cy, cz;
    logic [31:0] speeds [8];
    int sent;
    int nwp;
    int spread;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(wpf_pkg::ACT_TICK, 0, 0, 0, 24'hFFFFFF);
    send_word(wpf_pkg::ACT_APP, 32'h0001_0000, 0, 0, 24'd0);
    send_word(wpf_pkg::ACT_TICK, 0, 0, 0, 24'h010000);
    send_word(ACT_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_word(wpf_pkg::ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0);
    send_word(wpf_pkg::ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'd0);
    write_speed(32'h0001_0000);
    send_word(wpf_pkg::ACT_SET, 0, 0, 0, 24'd0);
    send_word(wpf_pkg::ACT_APP, 0, 0, 0, 24'd0);
    send_word(wpf_pkg::ACT_APP, 32'h0003_0000, 32'hFFFC_0000, 32'h0000_8000, 24'd0);
    send_word(wpf_pkg::ACT_TICK, 0, 0, 0, 24'h000100);
    send_word(wpf_pkg::ACT_TICK, 0, 0, 0, 24'h000000);
    send_word(wpf_pkg::ACT_TICK, 0, 0, 0, 24'hFFFFFF);
    write_speed(32'hFFFF_FFFF);
    for (int i = 0; i < 17; i++) send_word(wpf_pkg::ACT_APP, 32'(i), 0, 32'(-i), 24'd0);
    send_word(wpf_pkg::ACT_TICK, 0, 0, 0, 24'hFFFFFF);

    speeds = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100, $urandom, $urandom,
               32'h0010_0000, 32'h0000_0001};
    for (int p = 0; p < 8; p++) begin
      write_speed(speeds[p]);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 57 : 23);
      sent = 0;
      while (sent < 175) begin
        if ($urandom_range(99) < 8) begin
          send_word(2'($urandom), $urandom, $urandom, $urandom, 24'($urandom));
          sent++;
        end else begin
          if ($urandom_range(9) == 0) begin
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
          end else begin
            cx = near(0, 22);
            cy = near(0, 22);
            cz = near(0, 22);
          end
          send_word(wpf_pkg::ACT_SET, cx, cy, cz, 24'($urandom));
          nwp = $urandom_range(1, 18);
          spread = $urandom_range(2, 21);
          for (int k = 0; k < nwp; k++) begin
            if ($urandom_range(7) == 0) send_word(wpf_pkg::ACT_APP, cx, cy, cz, 24'd0);
            else send_word(wpf_pkg::ACT_APP, near(cx, spread), near(cy, spread),
                           near(cz, spread), 24'd0);
          end
          for (int k = $urandom_range(1, 10); k > 0; k--) begin
            send_word(wpf_pkg::ACT_TICK, 0, 0, 0, tick_len());
            sent++;
          end
          sent += nwp + 1;
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
